FILE: sv/gba_pkg.sv
// Shared constants and codes of the group bitmap inode allocator.
package gba_pkg;

    localparam int MAX_GROUPS      = 16;
    localparam int BITS_PER_GROUP  = 1024;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_GROUP = BITS_PER_GROUP / WORD_BITS;
    localparam int GROUP_W         = 4;
    localparam int WORD_W          = 4;
    localparam int BIT_W           = 10;
    localparam int ADDR_W          = GROUP_W + WORD_W;
    localparam int BITMAP_WORDS    = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int CNT_W           = 11;
    localparam int TOTAL_W         = 15;
    localparam int NG_W            = 5;

    localparam logic [CNT_W-1:0]   CNT_MAX   = 11'h7FF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 15'h7FFF;

    localparam logic [NG_W-1:0]  NG_RESET  = 5'd16;
    localparam logic [CNT_W-1:0] IPG_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] IPG_MIN   = 11'd8;
    localparam logic [CNT_W-1:0] IPG_MAX   = 11'd1024;
    localparam logic [NG_W-1:0]  NG_MAX    = 5'd16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FREED     = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic REG_GROUPS = 1'b0;
    localparam logic REG_IPG    = 1'b1;

endpackage

FILE: sv/group_bitmap_inode_allocator.sv
// Top level of the group bitmap inode allocator.
//
// Requests enter on in_valid/in_stall; one result per request leaves on
// out_valid/out_stall. in_stall is high while a request is in progress.
// An allocate request first reduces goal_group modulo the group count
// by repeated subtraction, then walks groups from there. Each group gets
// a count check, then its bitmap words, ceil(group size/64) at most, are
// read from the bitmap RAM (one read port) and checked one at a time.
// A free request goes through the bit-serial divider, then a read and a
// write of one bitmap word; a number beyond the groups in use is ignored
// after the divider, and number zero is ignored without it.
// The result sits in an output register; a new request is taken while it
// waits, and the next result holds in the sequencer until it is taken.
// Reset clears all counts and the bitmap valid bits at once, with no
// clearing pass. Configuration is to be written through the APB port only
// while idle; the block itself does not enforce this.
module group_bitmap_inode_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [3:0]                  goal_group,
    input  logic [14:0]                 target_number,
    input  logic                        is_directory,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [14:0]                 allocated_number,
    output logic [1:0]                  status,
    output logic [3:0]                  group_index,
    output logic [10:0]                 group_free,
    output logic [10:0]                 group_directories,
    output logic [10:0]                 group_unused_tail,
    output logic [14:0]                 total_free
);

    localparam int GW = gba_pkg::GROUP_W;
    localparam int WW = gba_pkg::WORD_W;
    localparam int CW = gba_pkg::CNT_W;
    localparam int TW = gba_pkg::TOTAL_W;
    localparam int NW = gba_pkg::NG_W;
    localparam int AW = gba_pkg::ADDR_W;
    localparam int DW = gba_pkg::WORD_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_GRP  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCHK = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [NW-1:0] groups_reg;
    logic [CW-1:0] ipg_cfg_reg;
    logic          cfg_wr;

    logic [3:0]    state_reg, state_next;
    logic          act_reg, act_next;
    logic          dir_reg, dir_next;
    logic [GW-1:0] cand_reg, cand_next;
    logic [NW-1:0] n_reg, n_next;
    logic [WW-1:0] word_reg, word_next;
    logic [gba_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic [NW-1:0] ng_reg, ng_next;
    logic [CW-1:0] ipg_reg, ipg_next;
    logic [1:0]    stat_reg, stat_next;
    logic          have_reg, have_next;
    logic [TW-1:0] num_reg, num_next;

    logic [CW-1:0] used_reg [gba_pkg::MAX_GROUPS];
    logic [CW-1:0] dirs_reg [gba_pkg::MAX_GROUPS];
    logic [CW-1:0] hw_reg   [gba_pkg::MAX_GROUPS];
    logic [gba_pkg::MAX_GROUPS-1:0] touched_reg;
    logic [TW-1:0] total_reg;
    logic [gba_pkg::BITMAP_WORDS-1:0] wvalid_reg;
    logic          rvalid_reg;

    logic [TW-1:0]  out_num_reg, out_fr_reg;
    logic [1:0]     out_stat_reg;
    logic [GW-1:0]  out_grp_reg;
    logic [CW-1:0]  out_free_reg, out_dirs_reg, out_tail_reg;
    logic           out_valid_reg;
    logic           out_load;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [DW-1:0]  ram_wdata, ram_q, word_eff;
    logic [DW-1:0]  lim_mask, free_mask;
    logic [5:0]     hit;
    logic [WW-1:0]  last_word;
    logic [GW-1:0]  cand_inc;
    logic           wrap;
    logic [NW-1:0]  ng_eff;
    logic [CW-1:0]  ipg_eff;

    logic           div_start, div_done;
    logic [TW-1:0]  div_q;
    logic [CW-1:0]  div_r;

    logic [2*CW-1:0]   cap;
    logic [TW-1:0]     num_calc;
    logic [CW-1:0]     used_c, hw_c, bit_p1;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == gba_pkg::REG_IPG) ? {21'd0, ipg_cfg_reg}
                                                   : {27'd0, groups_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg  <= gba_pkg::NG_RESET;
            ipg_cfg_reg <= gba_pkg::IPG_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gba_pkg::REG_GROUPS)
            begin
                groups_reg <= pwdata[NW-1:0];
            end
            else
            begin
                ipg_cfg_reg <= pwdata[CW-1:0];
            end
        end
    end

    assign ng_eff  = (groups_reg == '0) ? NW'(1)
                   : (groups_reg > gba_pkg::NG_MAX) ? gba_pkg::NG_MAX : groups_reg;
    assign ipg_eff = (ipg_cfg_reg < gba_pkg::IPG_MIN) ? gba_pkg::IPG_MIN
                   : (ipg_cfg_reg > gba_pkg::IPG_MAX) ? gba_pkg::IPG_MAX : ipg_cfg_reg;

    // bitmap storage
    assign ram_addr = {cand_reg, word_reg};

    gba_ram #(
        .WIDTH(DW),
        .DEPTH(gba_pkg::BITMAP_WORDS)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(ram_wdata),
        .raddr(ram_addr),
        .rdata(ram_q)
    );

    gba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (target_number - TW'(1)),
        .divisor  (ipg_eff),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    assign word_eff = rvalid_reg ? ram_q : '0;

    always_comb
    begin
        for (int k = 0; k < DW; k++)
        begin
            lim_mask[k] = {1'b0, word_reg, 6'(k)} < ipg_reg;
        end
        free_mask = ~word_eff & lim_mask;
        hit = '0;
        for (int k = DW - 1; k >= 0; k--)
        begin
            if (free_mask[k])
            begin
                hit = 6'(k);
            end
        end
    end

    assign last_word = WW'((ipg_reg - CW'(1)) >> 6);
    assign wrap      = ({1'b0, cand_reg} + NW'(1)) == ng_reg;
    assign cand_inc  = wrap ? '0 : cand_reg + GW'(1);
    assign used_c    = used_reg[cand_reg];
    assign hw_c      = hw_reg[cand_reg];
    assign bit_p1    = {1'b0, bit_reg} + CW'(1);
    assign cap       = (2*CW)'(ng_reg) * (2*CW)'(ipg_reg);
    assign num_calc  = TW'(cand_reg) * TW'(ipg_reg) + TW'(bit_p1);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign in_stall  = state_reg != S_IDLE;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        dir_next   = dir_reg;
        cand_next  = cand_reg;
        n_next     = n_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        ng_next    = ng_reg;
        ipg_next   = ipg_reg;
        stat_next  = stat_reg;
        have_next  = have_reg;
        num_next   = num_reg;
        ram_we     = 1'b0;
        ram_wdata  = word_eff;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = action;
                    dir_next  = is_directory;
                    ng_next   = ng_eff;
                    ipg_next  = ipg_eff;
                    cand_next = goal_group;
                    num_next  = '0;
                    have_next = 1'b0;
                    if (action == gba_pkg::ACT_ALLOC)
                    begin
                        state_next = S_MOD;
                    end
                    else if (target_number == '0)
                    begin
                        stat_next  = gba_pkg::ST_IGNORED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_MOD:
            begin
                if ({1'b0, cand_reg} >= ng_reg)
                begin
                    cand_next = GW'({1'b0, cand_reg} - ng_reg);
                end
                else
                begin
                    n_next     = '0;
                    state_next = S_GRP;
                end
            end
            S_GRP:
            begin
                if (n_reg == ng_reg)
                begin
                    stat_next  = gba_pkg::ST_NO_SPACE;
                    state_next = S_OUT;
                end
                else if (ipg_reg <= used_c)
                begin
                    n_next    = n_reg + NW'(1);
                    cand_next = cand_inc;
                end
                else
                begin
                    word_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (free_mask != '0)
                begin
                    bit_next   = {word_reg, hit};
                    ram_we     = 1'b1;
                    ram_wdata  = word_eff | (DW'(1) << hit);
                    state_next = S_UPD;
                end
                else if (word_reg == last_word)
                begin
                    n_next     = n_reg + NW'(1);
                    cand_next  = cand_inc;
                    state_next = S_GRP;
                end
                else
                begin
                    word_next  = word_reg + WW'(1);
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_q >= TW'(ng_reg))
                    begin
                        stat_next  = gba_pkg::ST_IGNORED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cand_next  = div_q[GW-1:0];
                        bit_next   = div_r[gba_pkg::BIT_W-1:0];
                        word_next  = div_r[gba_pkg::BIT_W-1:6];
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                ram_we     = 1'b1;
                ram_wdata  = word_eff & ~(DW'(1) << bit_reg[5:0]);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                have_next  = 1'b1;
                if (act_reg == gba_pkg::ACT_ALLOC)
                begin
                    stat_next = gba_pkg::ST_ALLOCATED;
                    num_next  = num_calc;
                end
                else
                begin
                    stat_next = gba_pkg::ST_FREED;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        dir_reg  <= dir_next;
        cand_reg <= cand_next;
        n_reg    <= n_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
        ng_reg   <= ng_next;
        ipg_reg  <= ipg_next;
        stat_reg <= stat_next;
        have_reg <= have_next;
        num_reg  <= num_next;
    end

    // group state and bitmap valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < gba_pkg::MAX_GROUPS; g++)
            begin
                used_reg[g] <= '0;
                dirs_reg[g] <= '0;
                hw_reg[g]   <= '0;
            end
            touched_reg <= '0;
            total_reg   <= '0;
            wvalid_reg  <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= wvalid_reg[ram_addr];
            if (ram_we)
            begin
                wvalid_reg[ram_addr] <= 1'b1;
            end
            if (state_reg == S_UPD)
            begin
                if (act_reg == gba_pkg::ACT_ALLOC)
                begin
                    touched_reg[cand_reg] <= 1'b1;
                    if (used_c < gba_pkg::CNT_MAX)
                    begin
                        used_reg[cand_reg] <= used_c + CW'(1);
                    end
                    if (dir_reg && dirs_reg[cand_reg] < gba_pkg::CNT_MAX)
                    begin
                        dirs_reg[cand_reg] <= dirs_reg[cand_reg] + CW'(1);
                    end
                    if (hw_c < bit_p1)
                    begin
                        hw_reg[cand_reg] <= bit_p1;
                    end
                    if (total_reg < gba_pkg::TOTAL_MAX)
                    begin
                        total_reg <= total_reg + TW'(1);
                    end
                end
                else
                begin
                    if (used_c != '0)
                    begin
                        used_reg[cand_reg] <= used_c - CW'(1);
                    end
                    if (dir_reg && dirs_reg[cand_reg] != '0)
                    begin
                        dirs_reg[cand_reg] <= dirs_reg[cand_reg] - CW'(1);
                    end
                    if (total_reg != '0)
                    begin
                        total_reg <= total_reg - TW'(1);
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_num_reg  <= num_reg;
            out_stat_reg <= stat_reg;
            out_grp_reg  <= have_reg ? cand_reg : '0;
            out_free_reg <= (have_reg && ipg_reg > used_c) ? ipg_reg - used_c : '0;
            out_dirs_reg <= have_reg ? dirs_reg[cand_reg] : '0;
            out_tail_reg <= (have_reg && ipg_reg > hw_c) ? ipg_reg - hw_c : '0;
            out_fr_reg   <= (cap > (2*CW)'(total_reg))
                            ? TW'(cap - (2*CW)'(total_reg)) : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign allocated_number  = out_num_reg;
    assign status            = out_stat_reg;
    assign group_index       = out_grp_reg;
    assign group_free        = out_free_reg;
    assign group_directories = out_dirs_reg;
    assign group_unused_tail = out_tail_reg;
    assign total_free        = out_fr_reg;

endmodule

FILE: sv/gba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/gba_div.sv
// Restoring divider, one quotient bit per cycle, for number to group and bit.
module gba_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gba_pkg::TOTAL_W-1:0] dividend,
    input  logic [gba_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [gba_pkg::TOTAL_W-1:0] quotient,
    output logic [gba_pkg::CNT_W-1:0]   remainder
);

    localparam logic [3:0] LAST_STEP = 4'(gba_pkg::TOTAL_W - 1);

    logic [gba_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [gba_pkg::TOTAL_W-1:0] quo_reg, quo_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [gba_pkg::CNT_W:0]     trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[gba_pkg::TOTAL_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? gba_pkg::CNT_W'(trial - {1'b0, divisor})
                            : gba_pkg::CNT_W'(trial);
            quo_next = {quo_reg[gba_pkg::TOTAL_W-2:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/gba_checker.sv
// Port-level checks of the allocator result channel, bound to the top level.
module gba_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [14:0] allocated_number,
    input  logic [1:0]  status,
    input  logic [3:0]  group_index,
    input  logic [10:0] group_free,
    input  logic [10:0] group_directories
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(allocated_number)
                                    && $stable(status))
        else $error("result changed while stalled");

    a_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gba_pkg::ST_ALLOCATED |-> allocated_number != '0)
        else $error("allocation returned number zero");

    a_num_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != gba_pkg::ST_ALLOCATED |-> allocated_number == '0)
        else $error("nonzero number without allocation");

    a_no_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gba_pkg::ST_NO_SPACE || status == gba_pkg::ST_IGNORED)
        |-> group_index == '0 && group_free == '0 && group_directories == '0)
        else $error("group fields set without a group");

endmodule

bind group_bitmap_inode_allocator gba_checker u_gba_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .allocated_number (allocated_number),
    .status           (status),
    .group_index      (group_index),
    .group_free       (group_free),
    .group_directories(group_directories)
);

FILE: test/group_bitmap_inode_allocator_test.sv
// Testbench of the group bitmap inode allocator: directed and random requests checked against a predictor.
module group_bitmap_inode_allocator_test;

    typedef struct packed {
        logic [14:0] number;
        logic [1:0]  code;
        logic [3:0]  grp;
        logic [10:0] gfree;
        logic [10:0] gdirs;
        logic [10:0] gtail;
        logic [14:0] tfree;
    } alloc_result_t;

    class allocator_scoreboard;
        bit            used_bits [gba_pkg::MAX_GROUPS][gba_pkg::BITS_PER_GROUP];
        int unsigned   used_cnt [gba_pkg::MAX_GROUPS];
        int unsigned   dir_cnt [gba_pkg::MAX_GROUPS];
        int unsigned   high_mark [gba_pkg::MAX_GROUPS];
        int unsigned   total_used;
        int unsigned   ngroups_reg;
        int unsigned   ipg_reg;
        alloc_result_t pending_q[$];
        int            errors;

        function new();
            ngroups_reg = gba_pkg::NG_RESET;
            ipg_reg = gba_pkg::IPG_RESET;
        endfunction

        function int unsigned sat_sub(int unsigned a, int unsigned b);
            return (a > b) ? a - b : 0;
        endfunction

        function void note_request(logic act, logic [3:0] goal, logic [14:0] target,
                                   logic dir);
            int unsigned ng, ipg, cand, bit_i, idx;
            bit found;
            alloc_result_t r;
            ng = (ngroups_reg < 1) ? 1 : (ngroups_reg > gba_pkg::MAX_GROUPS)
                 ? gba_pkg::MAX_GROUPS : ngroups_reg;
            ipg = (ipg_reg < 8) ? 8 : (ipg_reg > gba_pkg::BITS_PER_GROUP)
                  ? gba_pkg::BITS_PER_GROUP : ipg_reg;
            r = '0;
            r.code = gba_pkg::ST_IGNORED;
            found = 0;
            if (act == gba_pkg::ACT_ALLOC) begin
                r.code = gba_pkg::ST_NO_SPACE;
                for (int n = 0; n < ng && !found; n++) begin
                    cand = (goal + n) % ng;
                    if (sat_sub(ipg, used_cnt[cand]) == 0)
                        continue;
                    for (int b = 0; b < ipg; b++)
                        if (!used_bits[cand][b])
                        begin
                            bit_i = b;
                            found = 1;
                            break;
                        end
                end
                if (found) begin
                    used_bits[cand][bit_i] = 1;
                    if (used_cnt[cand] < gba_pkg::CNT_MAX) used_cnt[cand]++;
                    if (dir && dir_cnt[cand] < gba_pkg::CNT_MAX) dir_cnt[cand]++;
                    if (high_mark[cand] < bit_i + 1) high_mark[cand] = bit_i + 1;
                    if (total_used < gba_pkg::TOTAL_MAX) total_used++;
                    r.number = 15'(cand * ipg + bit_i + 1);
                    r.code = gba_pkg::ST_ALLOCATED;
                end
            end else if (target != 0) begin
                idx = target - 1;
                cand = idx / ipg;
                bit_i = idx % ipg;
                if (cand < ng) begin
                    used_bits[cand][bit_i] = 0;
                    used_cnt[cand] = sat_sub(used_cnt[cand], 1);
                    if (dir) dir_cnt[cand] = sat_sub(dir_cnt[cand], 1);
                    total_used = sat_sub(total_used, 1);
                    r.code = gba_pkg::ST_FREED;
                    found = 1;
                end
            end
            if (found) begin
                r.grp = 4'(cand);
                r.gfree = 11'(sat_sub(ipg, used_cnt[cand]));
                r.gdirs = 11'(dir_cnt[cand]);
                r.gtail = 11'(sat_sub(ipg, high_mark[cand]));
            end
            r.tfree = 15'(sat_sub(ng * ipg, total_used));
            pending_q.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.number !== e.number) begin
                $error("allocated_number exp %0d got %0d", e.number, got.number); errors++;
            end
            if (got.code !== e.code) begin
                $error("status exp %0d got %0d", e.code, got.code); errors++;
            end
            if (got.grp !== e.grp) begin
                $error("group_index exp %0d got %0d", e.grp, got.grp); errors++;
            end
            if (got.gfree !== e.gfree) begin
                $error("group_free exp %0d got %0d", e.gfree, got.gfree); errors++;
            end
            if (got.gdirs !== e.gdirs) begin
                $error("group_directories exp %0d got %0d", e.gdirs, got.gdirs); errors++;
            end
            if (got.gtail !== e.gtail) begin
                $error("group_unused_tail exp %0d got %0d", e.gtail, got.gtail); errors++;
            end
            if (got.tfree !== e.tfree) begin
                $error("total_free exp %0d got %0d", e.tfree, got.tfree); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic        action;
    logic [3:0]  goal_group;
    logic [14:0] target_number;
    logic        is_directory;
    logic        out_valid, out_stall;
    logic [14:0] allocated_number;
    logic [1:0]  status;
    logic [3:0]  group_index;
    logic [10:0] group_free, group_directories, group_unused_tail;
    logic [14:0] total_free;

    allocator_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  idle_cycles;
    int  issued;

    group_bitmap_inode_allocator dut (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        sb = new();
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; action = gba_pkg::ACT_ALLOC; goal_group = '0; target_number = '0;
        is_directory = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
    end

    // receiver side: random stall, optional long hold-off
    initial begin
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_off) out_stall <= 1;
            else out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({allocated_number, status, group_index, group_free,
                             group_directories, group_unused_tail, total_free});
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input int unsigned value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= (idx == gba_pkg::REG_IPG) ? 3'd4 : 3'd0;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == gba_pkg::REG_GROUPS) sb.ngroups_reg = value & 32'h1F;
        else sb.ipg_reg = value & 32'h7FF;
    endtask

    task automatic send_request(logic act, logic [3:0] goal, logic [14:0] target, logic dir);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        action <= act; goal_group <= goal; target_number <= target; is_directory <= dir;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(act, goal, target, dir);
        issued++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [14:0] live_target();
        int unsigned ng, ipg;
        ng = (sb.ngroups_reg < 1) ? 1 : (sb.ngroups_reg > 16) ? 16 : sb.ngroups_reg;
        ipg = (sb.ipg_reg < 8) ? 8 : (sb.ipg_reg > 1024) ? 1024 : sb.ipg_reg;
        return 15'($urandom_range(ng * ipg, 1));
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: send_request(gba_pkg::ACT_FREE, 4'($urandom), 15'($urandom),
                                1'($urandom));
                1, 2, 3: send_request(gba_pkg::ACT_FREE, 4'($urandom), live_target(),
                                      1'($urandom));
                default: send_request(gba_pkg::ACT_ALLOC, 4'($urandom), 15'($urandom),
                                      1'($urandom));
            endcase
        end
    endtask

    initial begin
        send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0; idle_cycles = 0; issued = 0;
        @(posedge rst_n);
        @(posedge clk);
        // directed: tiny pool to reach no-space, frees out of range and of zero
        write_reg(gba_pkg::REG_GROUPS, 0);
        write_reg(gba_pkg::REG_IPG, 3);
        for (int i = 0; i < 9; i++) send_request(gba_pkg::ACT_ALLOC, 4'hF, '0, i[0]);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd0, 1'b1);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'h7FFF, 1'b1);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd9, 1'b0);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd3, 1'b1);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd3, 1'b1);
        send_request(gba_pkg::ACT_ALLOC, 4'd0, '0, 1'b1);
        drain();
        write_reg(gba_pkg::REG_GROUPS, 31);
        write_reg(gba_pkg::REG_IPG, 2047);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd16384, 1'b1);
        send_request(gba_pkg::ACT_FREE, 4'd0, 15'd16385, 1'b0);
        send_request(gba_pkg::ACT_ALLOC, 4'hF, '0, 1'b1);
        send_request(gba_pkg::ACT_ALLOC, 4'h0, '0, 1'b0);
        drain();

        write_reg(gba_pkg::REG_GROUPS, 3);
        write_reg(gba_pkg::REG_IPG, 8);
        send_idle_pct = 31; recv_idle_pct = 63;
        random_phase(150);
        drain();

        write_reg(gba_pkg::REG_GROUPS, 16);
        write_reg(gba_pkg::REG_IPG, 70);
        send_idle_pct = 63; recv_idle_pct = 31;
        random_phase(130);
        hold_off = 1;
        fork
            random_phase(10);
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();

        write_reg(gba_pkg::REG_GROUPS, 1);
        write_reg(gba_pkg::REG_IPG, 1024);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(140);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: group_bitmap_inode_allocator.f
sv/gba_pkg.sv
sv/gba_ram.sv
sv/gba_div.sv
sv/group_bitmap_inode_allocator.sv
sv/gba_checker.sv
test/group_bitmap_inode_allocator_test.sv
